// ===== hdl/cbz_pkg.sv =====
// Shared types and constants of the B-spline to Bezier converter.
`timescale 1ns / 1ps
`default_nettype none

package cbz_pkg;

    // Blend selected for one Bezier point.
    typedef enum logic [1:0] {
        KIND_JOINT0 = 2'd0,  // (h0 + 4 h1 + h2) / 6, first joint of an unsnapped curve
        KIND_THIRD1 = 2'd1,  // (2 h1 + h2) / 3
        KIND_THIRD2 = 2'd2,  // (h1 + 2 h2) / 3
        KIND_JOINT  = 2'd3   // (h1 + 4 h2 + p) / 6
    } t_kind;

    // Control that travels beside each word through the datapath.
    typedef struct packed {
        logic valid;
        logic end_of_run;
        logic end_of_curve;
    } t_tag;

    // Points taken into the current curve; saturates at full.
    localparam logic [2:0] CNT_FULL         = 3'd4;
    localparam logic [2:0] CNT_SEGMENT      = 3'd3;
    localparam logic [2:0] CNT_SNAP_JOINT   = 3'd2;

    // Pushes per word: main one, plus two for each snapped end.
    localparam logic [2:0] PUSH_ONE         = 3'd1;
    localparam logic [2:0] PUSH_END_REPEAT  = 3'd2;
    localparam logic [2:0] PUSH_MAX         = 3'd5;

    // Results a push makes.
    localparam logic [2:0] RES_NONE         = 3'd0;
    localparam logic [2:0] RES_SNAP_JOINT   = 3'd1;
    localparam logic [2:0] RES_SEGMENT      = 3'd3;
    localparam logic [2:0] RES_FIRST_SEG    = 3'd4;

endpackage

`default_nettype wire

// ===== hdl/cbz_ifs.sv =====
// Valid/ready channel interfaces for de Boor points and Bezier points.
`timescale 1ns / 1ps
`default_nettype none

interface cbz_point_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          final_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output final_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input final_point, output ready);
endinterface

interface cbz_bez_if #(parameter int COORD_WIDTH = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] bez_x;
    logic signed [COORD_WIDTH-1:0] bez_y;
    logic signed [COORD_WIDTH-1:0] bez_z;
    logic                          end_of_run;
    logic                          end_of_curve;

    modport source (output valid, output bez_x, output bez_y, output bez_z,
                    output end_of_run, output end_of_curve, input ready);
    modport sink   (input valid, input bez_x, input bez_y, input bez_z,
                    input end_of_run, input end_of_curve, output ready);
endinterface

`default_nettype wire

// ===== hdl/cbz_seq.sv =====
// Point register, history and push sequencer that forms one weighted sum per cycle while enabled.
`timescale 1ns / 1ps
`default_nettype none

module cbz_seq #(
    parameter  int COORD_WIDTH = 24,
    localparam int SUM_WIDTH   = COORD_WIDTH + 3
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_snap,
    cbz_point_if.sink                      i_pt,
    output logic [2:0][SUM_WIDTH-1:0]      o_sum,
    output cbz_pkg::t_tag                  o_tag
);

    localparam logic [SUM_WIDTH-1:0] SUM_ROUND = SUM_WIDTH'(3);

    // Item register and history
    logic                              r_item_valid, n_item_valid;
    logic                              r_fin, n_fin;
    logic [2:0][COORD_WIDTH-1:0]       r_pt;
    logic [2:0][2:0][COORD_WIDTH-1:0]  r_hist;
    logic [2:0]                        r_pushes, n_pushes;
    logic [1:0]                        r_idx, n_idx;
    logic [2:0]                        r_cnt, n_cnt;
    logic                              r_curve_snap, n_curve_snap;
    logic [2:0][SUM_WIDTH-1:0]         r_sum, n_sum;
    cbz_pkg::t_tag                     r_tag, n_tag;

    logic                              w_load;
    logic                              w_shift;
    logic                              w_new_curve;
    logic [2:0]                        w_nres;
    logic                              w_last_res;
    logic                              w_extra;
    cbz_pkg::t_kind                    w_kind;
    logic signed [SUM_WIDTH-1:0]       w_a [3];
    logic signed [SUM_WIDTH-1:0]       w_b [3];
    logic signed [SUM_WIDTH-1:0]       w_c [3];

    // Results of the current push and which one is up
    always_comb begin
        w_extra = (r_cnt == cbz_pkg::CNT_SEGMENT) && !r_curve_snap;
        if (r_cnt >= cbz_pkg::CNT_SEGMENT) begin
            w_nres = w_extra ? cbz_pkg::RES_FIRST_SEG : cbz_pkg::RES_SEGMENT;
            w_kind = w_extra ? cbz_pkg::t_kind'(r_idx) : cbz_pkg::t_kind'(r_idx + 2'd1);
        end else if ((r_cnt == cbz_pkg::CNT_SNAP_JOINT) && r_curve_snap) begin
            w_nres = cbz_pkg::RES_SNAP_JOINT;
            w_kind = cbz_pkg::KIND_JOINT;
        end else begin
            w_nres = cbz_pkg::RES_NONE;
            w_kind = cbz_pkg::KIND_JOINT;
        end
        w_last_res = (w_nres == cbz_pkg::RES_NONE) || ({1'b0, r_idx} == (w_nres - 3'd1));
    end

    // Take a new word when empty or when the last push of this one retires; none in reset
    assign i_pt.ready = i_rst_n
                     && (!r_item_valid
                         || (i_en && w_last_res && (r_pushes == cbz_pkg::PUSH_ONE)));
    assign w_load = i_pt.valid && i_pt.ready;

    // Advance the push sequence, then load
    always_comb begin
        n_item_valid = r_item_valid;
        n_fin        = r_fin;
        n_pushes     = r_pushes;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_curve_snap = r_curve_snap;
        w_shift      = 1'b0;
        w_new_curve  = 1'b0;
        if (i_en && r_item_valid) begin
            if (w_last_res) begin
                w_shift  = 1'b1;
                n_idx    = '0;
                n_pushes = r_pushes - 3'd1;
                if (r_cnt != cbz_pkg::CNT_FULL) begin
                    n_cnt = r_cnt + 3'd1;
                end
                if (r_pushes == cbz_pkg::PUSH_ONE) begin
                    n_item_valid = 1'b0;
                    if (r_fin) begin
                        n_cnt = '0;
                    end
                end
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
        if (w_load) begin
            n_item_valid = 1'b1;
            n_fin        = i_pt.final_point;
            n_idx        = '0;
            w_new_curve  = (n_cnt == '0);
            if (w_new_curve) begin
                n_curve_snap = i_snap;
            end
            n_pushes = cbz_pkg::PUSH_ONE
                     + ((w_new_curve && i_snap) ? cbz_pkg::PUSH_END_REPEAT : 3'd0)
                     + ((i_pt.final_point && n_curve_snap) ? cbz_pkg::PUSH_END_REPEAT : 3'd0);
        end
    end

    // Weighted sum plus half the divisor, per axis
    always_comb begin
        for (int ax = 0; ax < 3; ax++) begin
            if (w_kind == cbz_pkg::KIND_JOINT0) begin
                w_a[ax] = SUM_WIDTH'($signed(r_hist[0][ax]));
                w_b[ax] = SUM_WIDTH'($signed(r_hist[1][ax]));
                w_c[ax] = SUM_WIDTH'($signed(r_hist[2][ax]));
            end else begin
                w_a[ax] = SUM_WIDTH'($signed(r_hist[1][ax]));
                w_b[ax] = SUM_WIDTH'($signed(r_hist[2][ax]));
                w_c[ax] = SUM_WIDTH'($signed(r_pt[ax]));
            end
            case (w_kind)
                cbz_pkg::KIND_THIRD1: n_sum[ax] = (w_a[ax] <<< 2) + (w_b[ax] <<< 1) + SUM_ROUND;
                cbz_pkg::KIND_THIRD2: n_sum[ax] = (w_a[ax] <<< 1) + (w_b[ax] <<< 2) + SUM_ROUND;
                default:              n_sum[ax] = w_a[ax] + (w_b[ax] <<< 2) + w_c[ax] + SUM_ROUND;
            endcase
        end
    end

    // Tag for the word formed this cycle
    always_comb begin
        n_tag.valid        = r_item_valid && (w_nres != cbz_pkg::RES_NONE);
        n_tag.end_of_run   = w_last_res && (r_pushes == cbz_pkg::PUSH_ONE);
        n_tag.end_of_curve = w_last_res && (r_pushes == cbz_pkg::PUSH_ONE) && r_fin;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
            r_pushes     <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_curve_snap <= 1'b0;
            r_tag        <= '0;
        end else begin
            r_item_valid <= n_item_valid;
            r_pushes     <= n_pushes;
            r_idx        <= n_idx;
            r_cnt        <= n_cnt;
            r_curve_snap <= n_curve_snap;
            if (i_en) begin
                r_tag <= n_tag;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_fin <= n_fin;
        if (w_load) begin
            r_pt[0] <= i_pt.point_x;
            r_pt[1] <= i_pt.point_y;
            r_pt[2] <= i_pt.point_z;
        end
        if (w_shift) begin
            r_hist[0] <= r_hist[1];
            r_hist[1] <= r_hist[2];
            r_hist[2] <= r_pt;
        end
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;
    assign o_tag = r_tag;

`ifndef SYNTHESIS
    a_cnt_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= cbz_pkg::CNT_FULL)
        else $error("point count past saturation");
    a_pushes_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_valid |-> ((r_pushes != 3'd0) && (r_pushes <= cbz_pkg::PUSH_MAX)))
        else $error("push count out of range for held word");
`endif

endmodule

`default_nettype wire

// ===== hdl/cbz_div6.sv =====
// Two-stage floor division of a rounded weighted sum by six, one axis.
`timescale 1ns / 1ps
`default_nettype none

module cbz_div6 #(
    parameter  int COORD_WIDTH = 24,
    localparam int SUM_WIDTH   = COORD_WIDTH + 3
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic signed [SUM_WIDTH-1:0]   i_sum,
    output logic        [COORD_WIDTH-1:0]      o_quot
);

    // Biased dividend width; the bias is a multiple of three above the low word
    localparam int                 V_WIDTH  = COORD_WIDTH + 3;
    localparam logic [V_WIDTH:0]   TWO_POW  = {1'b1, {V_WIDTH{1'b0}}};
    localparam logic [V_WIDTH-1:0] RECIP    = V_WIDTH'(TWO_POW / 3);
    localparam logic [V_WIDTH-1:0] OFFSET   = V_WIDTH'(3) << COORD_WIDTH;
    localparam logic [2:0]         DIVISOR3 = 3'd3;

    logic [SUM_WIDTH-2:0]   w_half;
    logic [V_WIDTH-1:0]     w_v;
    logic [2*V_WIDTH-1:0]   w_prod;
    logic [V_WIDTH-1:0]     r_q0;
    logic [2:0]             r_v_lo;
    logic [2:0]             w_rem;
    logic [COORD_WIDTH-1:0] w_quot;
    logic [COORD_WIDTH-1:0] r_quot;

    // Halve, bias positive, multiply by the reciprocal of three
    assign w_half = i_sum[SUM_WIDTH-1:1];
    assign w_v    = {w_half[SUM_WIDTH-2], w_half} + OFFSET;
    assign w_prod = {{V_WIDTH{1'b0}}, w_v} * {{V_WIDTH{1'b0}}, RECIP};

    // Estimate is low by at most one: fix it from the remainder's low bits
    assign w_rem  = r_v_lo - (r_q0[2:0] + {r_q0[1:0], 1'b0});
    assign w_quot = (w_rem >= DIVISOR3) ? (r_q0[COORD_WIDTH-1:0] + COORD_WIDTH'(1))
                                        : r_q0[COORD_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0   <= w_prod[2*V_WIDTH-1:V_WIDTH];
            r_v_lo <= w_v[2:0];
            r_quot <= w_quot;
        end
    end

    assign o_quot = r_quot;

endmodule

`default_nettype wire

// ===== hdl/cubic_bspline_to_bezier.sv =====
// Top level of the streaming uniform cubic B-spline to Bezier converter.
// Usage:
//   i_pt takes one de Boor point per word (valid/ready), final_point on the
//   last point of a curve. o_bez gives Bezier control points, one per word,
//   end_of_run on the last word caused by an input word, end_of_curve on the
//   last word of the curve.
//   i_cfg_wr_en/i_cfg_wr_data write snap_to_end; it is sampled when a curve
//   starts, so write it between curves.
// Timing:
//   The sequencer makes one Bezier point per cycle while o_bez is not
//   stalled, one push of the point history per input word (three with snap
//   at curve start, two more on the snapped last point). A push with no
//   result gives no point. A steady word gives three points; an unsnapped
//   curve's first three words give none.
//   The first result of a word passes, once it is accepted, through the
//   weighted sum, reciprocal multiply and correction into the output register.
// Reset and stall:
//   Reset empties the pipeline and starts a new curve with snap off. When
//   o_bez is stalled the whole datapath holds; i_pt still takes one word
//   into its holding register.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bspline_to_bezier #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_cfg_wr_en,
    input  wire logic   i_cfg_wr_data,
    cbz_point_if.sink   i_pt,
    cbz_bez_if.source   o_bez
);

    localparam int SUM_WIDTH = COORD_WIDTH + 3;

    logic                              r_snap;
    cbz_pkg::t_tag                     r_tag_a;
    cbz_pkg::t_tag                     r_tag_o;
    cbz_pkg::t_tag                     w_sum_tag;
    logic [2:0][SUM_WIDTH-1:0]         w_sum;
    logic [2:0][COORD_WIDTH-1:0]       w_quot;
    logic                              w_en;

    // Advance the datapath unless a finished word is stuck at the output
    assign w_en = !r_tag_o.valid || o_bez.ready;

    cbz_seq #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_snap  (r_snap),
        .i_pt    (i_pt),
        .o_sum   (w_sum),
        .o_tag   (w_sum_tag)
    );

    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        cbz_div6 #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_div6 (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_sum  ($signed(w_sum[ax])),
            .o_quot (w_quot[ax])
        );
    end

    // Config register and tag pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap  <= 1'b0;
            r_tag_a <= '0;
            r_tag_o <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_snap <= i_cfg_wr_data;
            end
            if (w_en) begin
                r_tag_a <= w_sum_tag;
                r_tag_o <= r_tag_a;
            end
        end
    end

    assign o_bez.valid        = r_tag_o.valid;
    assign o_bez.bez_x        = $signed(w_quot[0]);
    assign o_bez.bez_y        = $signed(w_quot[1]);
    assign o_bez.bez_z        = $signed(w_quot[2]);
    assign o_bez.end_of_run   = r_tag_o.end_of_run;
    assign o_bez.end_of_curve = r_tag_o.end_of_curve;

`ifndef SYNTHESIS
    a_curve_end_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_bez.valid && o_bez.end_of_curve) |-> o_bez.end_of_run)
        else $error("end_of_curve without end_of_run");
    a_mid_stage_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_tag_a.valid) |=> o_bez.valid)
        else $error("word lost between multiply stage and output");
    a_reset_empties_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_bez.valid)
        else $error("output valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== sim/cubic_bspline_to_bezier_test.sv =====
// Self-checking testbench for the streaming B-spline to Bezier converter.
`timescale 1ns / 1ps

module cubic_bspline_to_bezier_test;

    localparam int CW           = 24;
    localparam int ITEM_TARGET  = 380;
    localparam int SETTLE_WAIT  = 16;       // cycles past the last word before idle is trusted
    localparam int HOLD_CYCLES  = 400;      // long receiver hold-off
    localparam int HOLD_PHASE   = 2;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PRINT_CAP    = 30;

    typedef logic signed [CW-1:0] t_coord;
    typedef struct packed { t_coord x; t_coord y; t_coord z; } t_point;
    typedef struct packed { t_point pos; logic eor; logic eoc; } t_bez_word;
    typedef struct packed {
        logic   snap;
        t_point pt;
        logic   fin;
        logic   pinned;     // pin holds the first Bezier word of this point
        t_point pin;
    } t_dir_row;

    localparam t_coord CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_point P_MAX  = '{CMAX, CMAX, CMAX};
    localparam t_point P_MIN  = '{CMIN, CMIN, CMIN};
    localparam t_point P_ZERO = '{0, 0, 0};

    // Directed points: short curves, extremes, snap on and off, snap change mid-curve
    localparam t_dir_row DIR_ROWS [25] = '{
        '{1'b0, '{0, 0, 0},             1'b0, 1'b0, P_ZERO},
        '{1'b0, '{1, 1, 1},             1'b0, 1'b0, P_ZERO},
        '{1'b0, '{2, 2, 2},             1'b1, 1'b0, P_ZERO},   // too short, no words
        '{1'b0, P_MAX,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MAX,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MAX,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MAX,                  1'b1, 1'b1, P_MAX},
        '{1'b0, P_MIN,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MIN,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MIN,                  1'b0, 1'b0, P_ZERO},
        '{1'b0, P_MIN,                  1'b1, 1'b1, P_MIN},
        '{1'b0, '{CMAX, CMIN, 1},       1'b0, 1'b0, P_ZERO},
        '{1'b0, '{CMIN, CMAX, -1},      1'b0, 1'b0, P_ZERO},
        '{1'b0, '{CMAX, CMIN, 2},       1'b0, 1'b0, P_ZERO},
        '{1'b0, '{CMIN, CMAX, -2},      1'b0, 1'b0, P_ZERO},
        '{1'b0, '{5, -5, 7},            1'b1, 1'b0, P_ZERO},
        '{1'b1, '{5, -7, 123},          1'b1, 1'b1, '{5, -7, 123}},   // one-point curve
        '{1'b1, '{-1, -1, -1},          1'b0, 1'b1, '{-1, -1, -1}},
        '{1'b1, '{3, -3, 7},            1'b0, 1'b0, P_ZERO},
        '{1'b1, '{CMAX, CMIN, 0},       1'b1, 1'b0, P_ZERO},
        '{1'b0, '{10, 20, 30},          1'b0, 1'b0, P_ZERO},
        '{1'b1, '{40, 50, 60},          1'b0, 1'b0, P_ZERO},   // snap set mid-curve
        '{1'b1, '{-5, 6, -7},           1'b0, 1'b0, P_ZERO},
        '{1'b1, '{8, 9, 10},            1'b1, 1'b0, P_ZERO},
        '{1'b1, '{100, 200, 300},       1'b1, 1'b1, '{100, 200, 300}}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic i_cfg_wr_data;

    cbz_point_if #(.COORD_WIDTH(CW)) pt_ch ();
    cbz_bez_if   #(.COORD_WIDTH(CW)) bez_ch ();

    cubic_bspline_to_bezier #(.COORD_WIDTH(CW)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_pt          (pt_ch),
        .o_bez         (bez_ch)
    );

    // Converter state as predicted
    t_point    hist0, hist1, hist2;
    int        bsp_count;
    logic      snap_reg;
    logic      curve_snap;
    t_bez_word point_words [$];     // words caused by the point being predicted
    t_bez_word bez_expected [$];

    int  mismatches;
    int  items_sent;
    int  words_checked;
    int  curves_done;
    int  curves_snapped;
    int  cycle_count;
    bit  no_gaps;
    bit  hold_req;

    // Rounded blend floor((wa*a + wb*b + wc*c + 3) / 6) on one coordinate
    function automatic t_coord blend6(t_coord a, t_coord b, t_coord c, int wa, int wb, int wc);
        longint sum;
        longint q;
        sum = wa * longint'(a) + wb * longint'(b) + wc * longint'(c) + 3;
        q = sum / 6;
        if (sum % 6 < 0)
            q = q - 1;
        return t_coord'(q);
    endfunction

    function automatic void emit_blend(t_point a, t_point b, t_point c, int wa, int wb, int wc);
        t_bez_word w;
        w.pos.x = blend6(a.x, b.x, c.x, wa, wb, wc);
        w.pos.y = blend6(a.y, b.y, c.y, wa, wb, wc);
        w.pos.z = blend6(a.z, b.z, c.z, wa, wb, wc);
        w.eor = 1'b0;
        w.eoc = 1'b0;
        point_words = {point_words, w};
    endfunction

    // Take one point into the de Boor sequence and emit what it completes
    function automatic void take_point(t_point p);
        if (bsp_count >= 3) begin
            if (bsp_count == 3 && !curve_snap)
                emit_blend(hist0, hist1, hist2, 1, 4, 1);
            emit_blend(hist1, hist2, p, 4, 2, 0);
            emit_blend(hist1, hist2, p, 2, 4, 0);
            emit_blend(hist1, hist2, p, 1, 4, 1);
        end else if (bsp_count == 2 && curve_snap) begin
            emit_blend(hist1, hist2, p, 1, 4, 1);
        end
        hist0 = hist1;
        hist1 = hist2;
        hist2 = p;
        if (bsp_count < 4)
            bsp_count++;
    endfunction

    // Predict the Bezier words of one accepted point
    function automatic void predict_bezier(t_point p, logic fin);
        point_words.delete();
        if (bsp_count == 0) begin
            curve_snap = snap_reg;
            if (curve_snap) begin
                take_point(p);
                take_point(p);
            end
        end
        take_point(p);
        if (fin) begin
            if (curve_snap) begin
                take_point(p);
                take_point(p);
            end
            bsp_count = 0;
        end
        if (point_words.size() > 0) begin
            point_words[point_words.size() - 1].eor = 1'b1;
            point_words[point_words.size() - 1].eoc = fin;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: word %0d: %s", $time, words_checked, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Mostly full-range values, some near zero, some at the extremes
    function automatic t_coord pick_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return t_coord'($urandom);
        if (r < 85)
            return t_coord'(int'($urandom_range(0, 128)) - 64);
        case ($urandom_range(0, 3))
            0:       return CMAX;
            1:       return CMIN;
            2:       return t_coord'(0);
            default: return t_coord'(-1);
        endcase
    endfunction

    // Offer one point, wait for acceptance, queue its expected words
    task automatic send_point(input t_point pt, input logic fin, input logic pinned,
                              input t_point pin);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pt_ch.valid       <= 1'b1;
        pt_ch.point_x     <= pt.x;
        pt_ch.point_y     <= pt.y;
        pt_ch.point_z     <= pt.z;
        pt_ch.final_point <= fin;
        do @(posedge i_clk); while (!pt_ch.ready);
        predict_bezier(pt, fin);
        if (pinned && point_words.size() > 0)
            point_words[0].pos = pin;
        foreach (point_words[i])
            bez_expected = {bez_expected, point_words[i]};
        items_sent++;
        if (fin) begin
            curves_done++;
            if (curve_snap)
                curves_snapped++;
        end
    endtask

    // Drop valid, drain every expected word, then let the pipeline empty
    task automatic settle();
        @(negedge i_clk);
        pt_ch.valid <= 1'b0;
        while (bez_expected.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_snap(input logic value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        snap_reg = value;
    endtask

    task automatic send_curve();
        int r;
        int len;
        t_point pt;
        r = $urandom_range(0, 99);
        if (r < 15)
            len = $urandom_range(1, 3);
        else if (r < 95)
            len = $urandom_range(4, 10);
        else
            len = $urandom_range(12, 24);
        for (int i = 0; i < len; i++) begin
            pt.x = pick_coord();
            pt.y = pick_coord();
            pt.z = pick_coord();
            send_point(pt, i == len - 1, 1'b0, P_ZERO);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Time out a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL cubic_bspline_to_bezier");
        $finish;
    end

    // Receiver: random stalls, calm stretches, one long hold-off on request
    initial begin : bez_sink
        int r;
        int stall;
        int calm;
        stall = 0;
        calm = 0;
        bez_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                bez_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (calm == 0 && stall == 0) begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    calm = $urandom_range(40, 150);
                else if (r < 7)
                    stall = $urandom_range(15, 60);
                else if (r < 35)
                    stall = $urandom_range(1, 3);
            end
            if (calm > 0) begin
                calm--;
                bez_ch.ready <= 1'b1;
            end else if (stall > 0) begin
                stall--;
                bez_ch.ready <= 1'b0;
            end else begin
                bez_ch.ready <= 1'b1;
            end
        end
    end

    // Compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin : bez_check
        t_bez_word want;
        if (i_rst_n && bez_ch.valid && bez_ch.ready) begin
            if (bez_expected.size() == 0) begin
                report_mismatch("word with no expectation waiting");
            end else begin
                want = bez_expected.pop_front();
                check_field("bez_x", longint'(bez_ch.bez_x), longint'(want.pos.x));
                check_field("bez_y", longint'(bez_ch.bez_y), longint'(want.pos.y));
                check_field("bez_z", longint'(bez_ch.bez_z), longint'(want.pos.z));
                check_field("end_of_run", longint'(bez_ch.end_of_run), longint'(want.eor));
                check_field("end_of_curve", longint'(bez_ch.end_of_curve),
                            longint'(want.eoc));
            end
            words_checked++;
        end
    end

    initial begin : stimulus
        int phase;
        mismatches     = 0;
        items_sent     = 0;
        words_checked  = 0;
        curves_done    = 0;
        curves_snapped = 0;
        no_gaps        = 1'b0;
        hold_req       = 1'b0;
        hist0          = P_ZERO;
        hist1          = P_ZERO;
        hist2          = P_ZERO;
        bsp_count      = 0;
        snap_reg       = 1'b0;
        curve_snap     = 1'b0;
        i_rst_n           = 1'b0;
        i_cfg_wr_en       = 1'b0;
        i_cfg_wr_data     = 1'b0;
        pt_ch.valid       = 1'b0;
        pt_ch.point_x     = '0;
        pt_ch.point_y     = '0;
        pt_ch.point_z     = '0;
        pt_ch.final_point = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; change snap only once the block is idle
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].snap != snap_reg) begin
                settle();
                write_snap(DIR_ROWS[i].snap);
            end
            send_point(DIR_ROWS[i].pt, DIR_ROWS[i].fin, DIR_ROWS[i].pinned, DIR_ROWS[i].pin);
        end

        // Random phases of whole curves, each under one snap setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            if (phase < 2)
                write_snap(phase == 0);
            else
                write_snap(1'($urandom_range(0, 1)));
            no_gaps = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            repeat ($urandom_range(3, 8)) send_curve();
            phase++;
        end
        settle();

        $display("Run: %0d de Boor points in %0d curves (%0d snapped), %0d Bezier words checked,",
                 items_sent, curves_done, curves_snapped, words_checked);
        $display("     %0d random phases with random stalls and one %0d-cycle receiver hold-off.",
                 phase, HOLD_CYCLES);
        if (mismatches == 0)
            $display("PASS cubic_bspline_to_bezier");
        else
            $display("FAIL cubic_bspline_to_bezier");
        $finish;
    end

endmodule
